FILE: hdl/tdma_frame_number_sync_assert.svh
// Assertion macros for the frame number synchronizer.
`ifndef TDMA_FRAME_NUMBER_SYNC_ASSERT_SVH
`define TDMA_FRAME_NUMBER_SYNC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TFNS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFNS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tfns_pkg.sv
// Shared constants, codes and control types of the frame number synchronizer.
package tfns_pkg;

    localparam int HIST_DEPTH = 5;
    localparam int HYPER_LEN  = 2715648;
    localparam int FRAME_W    = 22;
    localparam int OFFS_W     = 23;
    localparam int TOL_W      = 10;
    localparam int SUM_W      = 24;
    localparam int TOL_RESET  = 16;
    localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_REPORT = 2'd1,
        MODE_FORCE  = 2'd2,
        MODE_START  = 2'd3
    } t_mode;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan;
        logic decide;
        logic sum;
        logic wrap;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_report;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

FILE: hdl/tdma_frame_number_sync.sv
// Steps: tick, forced tick and start go through capture, apply, sum, wrap and output load;
// a sync report also scans the filled history entries (1 to 5) and then decides the offset.
// Throughput: one item at a time; the next transfer is taken once the result sits in the
// output register, so a report, with its history scan, holds the input longer than other items.
// Reset (synchronous, active low): counter, offset, sync flag, history pointer and fill clear,
// tolerance returns to 16, output goes invalid; history contents are not cleared.
module tdma_frame_number_sync (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic [tfns_pkg::FRAME_W-1:0]  i_frame_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tfns_pkg::FRAME_W-1:0]  o_corrected_frame,
    output logic                          o_is_synced,
    output logic                          o_offset_updated,
    input  logic                          i_cfg_we,
    input  logic [tfns_pkg::TOL_W-1:0]    i_cfg_data
);
    import tfns_pkg::*;

    `include "tdma_frame_number_sync_assert.svh"

    localparam logic [FRAME_W-1:0] FRAME_LIMIT = FRAME_W'(HYPER_LEN);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_xfer;

    // An input transfer happens only in the idle state of the sequencer.
    assign w_in_xfer = i_in_valid && !o_in_stall;

    // Sequencer: capture, apply the mode, scan the history on reports, decide the
    // offset, add and wrap, then hand the result to the output register.
    tfns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath: local counter, offset, five-entry history ring, tolerance register
    // and the output register that lets a new item in while a result waits.
    tfns_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_mode            (i_mode),
        .i_frame_value     (i_frame_value),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_corrected_frame (o_corrected_frame),
        .o_is_synced       (o_is_synced),
        .o_offset_updated  (o_offset_updated)
    );

    // The wrapped frame never reaches the hyperframe length.
    `TFNS_ASSERT_IMP(a_frame_range, o_out_valid, o_corrected_frame < FRAME_LIMIT, "frame overflow")
    // Replacing the offset always leaves the block synchronized.
    `TFNS_ASSERT_IMP(a_update_synced, o_out_valid && o_offset_updated, o_is_synced, "not synced")
    // After a transfer the block is busy with that item.
    `TFNS_ASSERT_NXT(a_busy_after_xfer, w_in_xfer, o_in_stall, "input taken without going busy")

endmodule

FILE: hdl/tfns_ctrl.sv
// Sequencer of the frame number synchronizer.
module tfns_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tfns_pkg::t_stat i_stat,
    output tfns_pkg::t_cmd  o_cmd
);
    import tfns_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_DECIDE,
        S_SUM,
        S_WRAP,
        S_DONE
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:   if (i_in_valid) r_state <= S_APPLY;
                S_APPLY:  r_state <= i_stat.is_report ? S_SCAN : S_SUM;
                S_SCAN:   if (i_stat.scan_last) r_state <= S_DECIDE;
                S_DECIDE: r_state <= S_SUM;
                S_SUM:    r_state <= S_WRAP;
                S_WRAP:   r_state <= S_DONE;
                S_DONE:   if (i_stat.out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.apply    = (r_state == S_APPLY);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.decide   = (r_state == S_DECIDE);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.wrap     = (r_state == S_WRAP);
        o_cmd.load_out = (r_state == S_DONE) && i_stat.out_free;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: hdl/tfns_dp.sv
// Datapath of the frame number synchronizer: counter, offset, history and output register.
module tfns_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tfns_pkg::t_cmd                i_cmd,
    output tfns_pkg::t_stat               o_stat,
    input  logic [1:0]                    i_mode,
    input  logic [tfns_pkg::FRAME_W-1:0]  i_frame_value,
    input  logic                          i_cfg_we,
    input  logic [tfns_pkg::TOL_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tfns_pkg::FRAME_W-1:0]  o_corrected_frame,
    output logic                          o_is_synced,
    output logic                          o_offset_updated
);
    import tfns_pkg::*;

    localparam logic [FRAME_W-1:0]      LAST_FRAME = FRAME_W'(HYPER_LEN - 1);
    localparam logic [FRAME_W:0]        HL_W1      = (FRAME_W + 1)'(HYPER_LEN);
    localparam logic signed [SUM_W:0]   HL_S       = (SUM_W + 1)'(HYPER_LEN);
    localparam logic signed [SUM_W:0]   HL2_S      = (SUM_W + 1)'(2 * HYPER_LEN);
    localparam logic [IDX_W-1:0]        LAST_SLOT  = IDX_W'(HIST_DEPTH - 1);
    localparam logic [FILL_W-1:0]       FULL_FILL  = FILL_W'(HIST_DEPTH);

    t_mode                     r_mode;
    logic [FRAME_W-1:0]        r_value;
    logic [FRAME_W-1:0]        r_local;
    logic signed [OFFS_W-1:0]  r_offset;
    logic signed [OFFS_W-1:0]  r_hist [HIST_DEPTH];
    logic [IDX_W-1:0]          r_slot;
    logic [FILL_W-1:0]         r_fill;
    logic                      r_synced;
    logic [IDX_W-1:0]          r_idx;
    logic signed [OFFS_W-1:0]  r_best;
    logic                      r_updated;
    logic signed [SUM_W-1:0]   r_sum;
    logic [FRAME_W-1:0]        r_corr;
    logic [TOL_W-1:0]          r_tol;
    logic                      r_out_valid;
    logic [FRAME_W-1:0]        r_out_frame;
    logic                      r_out_synced;
    logic                      r_out_updated;

    logic [FRAME_W-1:0]        n_local;
    logic [FRAME_W:0]          w_forced;
    logic signed [OFFS_W-1:0]  w_raw;
    logic signed [OFFS_W-1:0]  w_entry;
    logic signed [SUM_W-1:0]   w_diff;
    logic [SUM_W-1:0]          w_mag;
    logic                      w_drift_ok;
    logic signed [SUM_W:0]     w_sext;
    logic signed [SUM_W:0]     n_corr;

    // Advance, load, clear or hold the local counter.
    always_comb begin
        w_forced = {1'b0, r_value} + (FRAME_W + 1)'(1);
        case (r_mode)
            MODE_TICK:   n_local = (r_local == LAST_FRAME) ? '0 : r_local + FRAME_W'(1);
            MODE_FORCE:  n_local = (w_forced >= HL_W1) ? FRAME_W'(w_forced - HL_W1)
                                                       : w_forced[FRAME_W-1:0];
            MODE_START:  n_local = '0;
            default:     n_local = r_local;
        endcase
    end

    assign w_raw   = $signed({1'b0, r_value}) - $signed({1'b0, r_local});
    assign w_entry = r_hist[r_idx];

    assign w_diff     = {r_best[OFFS_W-1], r_best} - {r_offset[OFFS_W-1], r_offset};
    assign w_mag      = w_diff[SUM_W-1] ? SUM_W'(-w_diff) : w_diff;
    assign w_drift_ok = (w_mag <= SUM_W'(r_tol));

    // Reduce the sum into hyperframe range; it lies within one period below
    // zero and under three periods above.
    always_comb begin
        w_sext = {r_sum[SUM_W-1], r_sum};
        if (w_sext < 0) begin
            n_corr = w_sext + HL_S;
        end else if (w_sext >= HL2_S) begin
            n_corr = w_sext - HL2_S;
        end else if (w_sext >= HL_S) begin
            n_corr = w_sext - HL_S;
        end else begin
            n_corr = w_sext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(TOL_RESET);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local  <= '0;
            r_offset <= '0;
            r_slot   <= '0;
            r_fill   <= '0;
            r_synced <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_local <= n_local;
                if (r_mode == MODE_REPORT) begin
                    r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + IDX_W'(1);
                    if (r_fill != FULL_FILL) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                end
            end
            if (i_cmd.decide && !(r_synced && w_drift_ok)) begin
                r_offset <= r_best;
                r_synced <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && r_mode == MODE_REPORT) begin
            r_hist[r_slot] <= w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= i_frame_value;
        end
        if (i_cmd.apply) begin
            r_idx     <= '0;
            r_updated <= 1'b0;
        end
        if (i_cmd.scan) begin
            if (r_idx == '0 || w_entry > r_best) begin
                r_best <= w_entry;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.decide) begin
            r_updated <= !(r_synced && w_drift_ok);
        end
        if (i_cmd.sum) begin
            r_sum <= $signed({2'b00, r_local}) + SUM_W'(r_offset);
        end
        if (i_cmd.wrap) begin
            r_corr <= n_corr[FRAME_W-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_frame   <= r_corr;
            r_out_synced  <= r_synced;
            r_out_updated <= r_updated;
        end
    end

    // Output register: set on load, drop after its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.is_report = (r_mode == MODE_REPORT);
    assign o_stat.scan_last = (FILL_W'(r_idx) + FILL_W'(1) >= r_fill);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_corrected_frame = r_out_frame;
    assign o_is_synced       = r_out_synced;
    assign o_offset_updated  = r_out_updated;

endmodule
